FILE: rtl/core/rotated_sorted_array_search_top_assert.svh
// assertion macros for the top-level rtl file
`ifndef ROTATED_SORTED_ARRAY_SEARCH_TOP_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_TOP_ASSERT_SVH

// checked property, off while in reset
`define RSAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also during reset
`define RSAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/rsas_pkg.sv
package rsas_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IDX_W        = CNT_W + 1;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_SEARCHED = 2'd0;
  localparam logic [1:0] ST_STORED   = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_CLEARED  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_EVAL,
    S_DONE
  } state_e;

endpackage

FILE: rtl/core/rotated_sorted_array_search_top.sv
// append, clear and unused codes: result beat in the cycle after the input beat
// search: probes until the key is hit or the window empties (more probes when
//   long runs of equal values force the shrink step)
// each probe passes S_RDB and S_EVAL: low/mid then high through the two memory read ports
// one item at a time; a waiting result blocks the next input beat
// reset clears the element count and control state; store contents stay unknown
`include "rotated_sorted_array_search_top_assert.svh"

module rotated_sorted_array_search_top
  import rsas_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // element store, two read ports, one write port
  logic signed [31:0] mem_q [MAX_ELEMENTS];
  logic signed [31:0] rda_q, rdb_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic               rea, reb;
  logic [ADDR_W-1:0]  ra, rb;

  // control and search window
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [IDX_W-1:0]  lo_q, hi_q, lo_n, hi_n;
  logic signed [IDX_W-1:0]  mid_q;
  logic [IDX_W-1:0]         mid_sum;
  logic signed [31:0]       key_q, vl_q;
  logic                     found_q;
  logic                     done, hit;

  // result register
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;
  logic      out_free, out_load;

  logic in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // memory: vm comes back on port a, vl then vh on port b
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= in_beat_i.value;
    end
    if (rea) begin
      rda_q <= mem_q[ra];
    end
    if (reb) begin
      rdb_q <= mem_q[rb];
    end
  end

  // probe decision and window update
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    done = 1'b0;
    hit  = 1'b0;
    unique case (state_q)
      S_RDA: begin
        if (lo_q > hi_q) done = 1'b1;
      end
      S_EVAL: begin
        if (rda_q == key_q) begin
          hit  = 1'b1;
          done = 1'b1;
        end else if (vl_q == rda_q && rda_q == rdb_q) begin
          // all three equal, shrink both ends
          lo_n = lo_q + IDX_W'(1);
          hi_n = hi_q - IDX_W'(1);
        end else if (vl_q <= rda_q) begin
          // left half sorted
          if (vl_q <= key_q && key_q <= rda_q) hi_n = mid_q - IDX_W'(1);
          else                                 lo_n = mid_q + IDX_W'(1);
        end else begin
          // right half sorted
          if (rda_q <= key_q && key_q <= rdb_q) lo_n = mid_q + IDX_W'(1);
          else                                  hi_n = mid_q - IDX_W'(1);
        end
        if (!hit && lo_n > hi_n) done = 1'b1;
      end
      default: ;
    endcase
  end

  // both ends are non-negative whenever the sum is used
  assign mid_sum = IDX_W'(lo_n) + IDX_W'(hi_n);

  always_comb begin
    rea = (state_q == S_RDA || state_q == S_EVAL) && !done;
    reb = rea || state_q == S_RDB;
    ra  = mid_sum[ADDR_W:1];
    rb  = (state_q == S_RDB) ? hi_q[ADDR_W-1:0] : lo_n[ADDR_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_beat_i.action == ACT_SEARCH) state_d = S_RDA;
      S_RDA:  state_d = done ? S_DONE : S_RDB;
      S_RDB:  state_d = S_EVAL;
      S_EVAL: state_d = done ? S_DONE : S_RDB;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: store writes, count, result beat
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = count_q[ADDR_W-1:0];
    count_d  = count_q;
    out_load = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_beat_i.action != ACT_SEARCH) begin
          out_load     = 1'b1;
          out_d.found  = 1'b0;
          out_d.status = ST_SEARCHED;
          unique case (in_beat_i.action)
            ACT_APPEND: begin
              if (count_q < CNT_W'(MAX_ELEMENTS)) begin
                mem_we       = 1'b1;
                count_d      = count_q + CNT_W'(1);
                out_d.status = ST_STORED;
              end else begin
                out_d.status = ST_DROPPED;
              end
            end
            ACT_CLEAR: begin
              count_d      = '0;
              out_d.status = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_d.found  = found_q;
          out_d.status = ST_SEARCHED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load)         out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else                  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_IDLE && in_acc) begin
        lo_q <= '0;
        hi_q <= $signed({1'b0, count_q}) - IDX_W'(1);
      end else if (state_q == S_RDA || state_q == S_EVAL) begin
        lo_q <= lo_n;
        hi_q <= hi_n;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) key_q <= in_beat_i.value;
    if (rea) mid_q <= $signed(mid_sum >> 1);
    if (state_q == S_RDB) vl_q <= rdb_q;
    if (done) found_q <= hit;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // checks
  `RSAS_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ELEMENTS), "element count above capacity")
  `RSAS_ASSERT(a_take_only_idle, !in_stall_o |-> state_q == S_IDLE, "input taken while busy")
  `RSAS_ASSERT(a_probe_window, (state_q == S_EVAL && state_d == S_RDB) |=> lo_q <= hi_q,
               "probe issued on an empty window")
  `RSAS_ASSERT(a_result_source,
               $rose(out_valid_o) |-> ($past(state_q == S_IDLE) || $past(state_q == S_DONE)),
               "result beat from a search step")
  `RSAS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

FILE: tb/rotated_sorted_array_search_top_tb.sv
module rotated_sorted_array_search_top_tb;
  import rsas_pkg::*;

  // the package names only three action codes; the fourth leaves the store alone but still gets a result beat
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  // random part stops once this many meaningful beats went in
  localparam int ITEM_TARGET = 1800;
  // cycles without any accepted beat before the run is declared hung
  localparam int QUIET_LIMIT = 20000;
  // receiver hold-off used to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  rotated_sorted_array_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the element store and the outcomes still owed by the block
  // ---------------------------------------------------------------------------
  logic signed [31:0] shadow_elems [MAX_ELEMENTS];
  int unsigned        shadow_count = 0;
  out_beat_t          pending_outcomes [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int burst_left     = 0;
  bit held_off       = 1'b0;

  // modified binary search over the shadow store, duplicates allowed
  function automatic logic key_present(logic signed [31:0] key);
    int lo;
    int hi;
    int mid;
    logic signed [31:0] vl;
    logic signed [31:0] vm;
    logic signed [31:0] vh;
    lo = 0;
    hi = int'(shadow_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      vl  = shadow_elems[lo];
      vm  = shadow_elems[mid];
      vh  = shadow_elems[hi];
      if (vm == key) return 1'b1;
      if (vl == vm && vm == vh) begin
        // all three ends equal: no half can be told sorted, shrink both ends
        lo++;
        hi--;
      end else if (vl <= vm) begin
        // left half ascending
        if (vl <= key && key <= vm) hi = mid - 1;
        else lo = mid + 1;
      end else begin
        // right half ascending
        if (vm <= key && key <= vh) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return 1'b0;
  endfunction

  // applies one beat to the shadow store and returns the outcome it causes
  function automatic out_beat_t shadow_store_step(in_beat_t b);
    out_beat_t r;
    r        = '0;
    r.status = ST_SEARCHED;
    case (b.action)
      ACT_APPEND: begin
        if (shadow_count < MAX_ELEMENTS) begin
          shadow_elems[shadow_count] = b.value;
          shadow_count++;
          r.status = ST_STORED;
        end else begin
          r.status = ST_DROPPED;
        end
      end
      ACT_SEARCH: begin
        r.found = key_present(b.value);
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        r.status     = ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: bursts of beats separated by random gaps
  // ---------------------------------------------------------------------------
  // fixed_res overrides the shadow outcome on rows whose answer is obvious;
  // the shadow store still sees every beat so its state stays in step
  task automatic push_beat(input in_beat_t b, input bit fixed, input out_beat_t fixed_res);
    out_beat_t res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    res = shadow_store_step(b);
    if (fixed) res = fixed_res;
    pending_outcomes.push_back(res);
    if (b.action != ACT_UNUSED) items_sent++;
  endtask

  task automatic send(input logic [1:0] action, input logic signed [31:0] value);
    in_beat_t b;
    b.action = action;
    b.value  = value;
    push_beat(b, 1'b0, '0);
  endtask

  // one data set: optional clear, a rotated ascending run (or plain noise),
  // then a batch of searches against it
  task automatic run_rotated_set(input int set_no);
    int      n;
    int      rot;
    int      n_keys;
    int      pick;
    int      idx;
    longint  cur;
    longint  step_cap;
    bit      noisy;
    logic signed [31:0] key;
    logic signed [31:0] vals [$];

    // set two fills the store completely and then overruns it
    if (set_no == 2) n = MAX_ELEMENTS + 3;
    else if ($urandom_range(0, 9) == 0) n = 0;
    else n = $urandom_range(1, 40);

    case ($urandom_range(0, 4))
      0: step_cap = 0;          // every element equal
      1: step_cap = 2;          // long runs of duplicates
      2: step_cap = 100;
      3: step_cap = 1 << 20;
      default: step_cap = 1 << 30;
    endcase

    case ($urandom_range(0, 3))
      0: cur = INT_MIN;
      1: cur = -longint'($urandom_range(0, 1000));
      default: cur = longint'($signed($urandom));
    endcase

    noisy = ($urandom_range(0, 6) == 0) && (set_no != 2);

    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        vals.push_back($signed($urandom));
      end else begin
        vals.push_back(cur[31:0]);
        cur += longint'($urandom_range(0, int'(step_cap)));
        if (cur > longint'(INT_MAX)) cur = INT_MAX;
      end
    end

    // most sets start from an empty store; the rest pile onto old contents
    if ($urandom_range(0, 7) != 0 || set_no == 2) send(ACT_CLEAR, $signed($urandom));

    rot = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      send(ACT_APPEND, vals[(i + rot) % n]);
      // broken sequences: stray unused codes and early searches in the middle
      pick = $urandom_range(0, 39);
      if (pick == 0) send(ACT_UNUSED, $signed($urandom));
      else if (pick == 1) send(ACT_SEARCH, vals[$urandom_range(0, i)]);
    end

    n_keys = (set_no == 2) ? 40 : $urandom_range(4, 20);
    for (int k = 0; k < n_keys; k++) begin
      pick = $urandom_range(0, 9);
      idx  = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (n == 0 || pick >= 8) key = $signed($urandom);
      else if (pick <= 4) key = vals[idx];
      else if (pick == 5) key = vals[idx] + 32'sd1;
      else if (pick == 6) key = vals[idx] - 32'sd1;
      else key = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
      send(ACT_SEARCH, key);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed rows: extremes, every action code, the empty store,
  // the all-equal shrink step and unsorted contents
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
    logic        fixed;
    logic        found;
    logic [1:0]  status;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    // empty store answers not found
    '{ACT_SEARCH, 32'h0000_0000, 1'b1, 1'b0, ST_SEARCHED},
    // unused code leaves everything alone
    '{ACT_UNUSED, 32'h0000_0000, 1'b1, 1'b0, ST_SEARCHED},
    // a rotated run touching both extremes: max max min min -1 0
    '{ACT_APPEND, 32'h7fff_ffff, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h7fff_ffff, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h8000_0000, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h8000_0000, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'hffff_ffff, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h0000_0000, 1'b1, 1'b0, ST_STORED},
    '{ACT_SEARCH, 32'h8000_0000, 1'b0, 1'b0, ST_SEARCHED},
    '{ACT_SEARCH, 32'h7fff_ffff, 1'b0, 1'b0, ST_SEARCHED},
    '{ACT_SEARCH, 32'h0000_0005, 1'b0, 1'b0, ST_SEARCHED},
    '{ACT_SEARCH, 32'hffff_ffff, 1'b0, 1'b0, ST_SEARCHED},
    // clear ignores its value, store is empty again
    '{ACT_CLEAR,  32'h5555_5555, 1'b1, 1'b0, ST_CLEARED},
    '{ACT_SEARCH, 32'hffff_ffff, 1'b1, 1'b0, ST_SEARCHED},
    // duplicates with equal ends and middle: 7 3 7 7 7
    '{ACT_APPEND, 32'h0000_0007, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h0000_0003, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h0000_0007, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h0000_0007, 1'b1, 1'b0, ST_STORED},
    '{ACT_APPEND, 32'h0000_0007, 1'b1, 1'b0, ST_STORED},
    '{ACT_SEARCH, 32'h0000_0003, 1'b0, 1'b0, ST_SEARCHED},
    '{ACT_SEARCH, 32'h0000_0008, 1'b0, 1'b0, ST_SEARCHED},
    // break the ordering, search still has to terminate
    '{ACT_APPEND, 32'hffff_fffb, 1'b1, 1'b0, ST_STORED},
    '{ACT_SEARCH, 32'hffff_fffb, 1'b0, 1'b0, ST_SEARCHED},
    '{ACT_UNUSED, 32'hffff_ffff, 1'b1, 1'b0, ST_SEARCHED}
  };

  initial begin : stimulus
    in_beat_t  b;
    out_beat_t fixed_res;
    int        set_no;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      b.action         = directed_plan[r].action;
      b.value          = directed_plan[r].value;
      fixed_res.found  = directed_plan[r].found;
      fixed_res.status = directed_plan[r].status;
      push_beat(b, directed_plan[r].fixed, fixed_res);
    end

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_rotated_set(set_no);
      set_no++;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // room for any stray result beat to show up
    repeat (50) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: stall pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stretch;
    int mode;
    @(posedge rst_ni);
    forever begin
      if (!held_off && items_sent >= 300) begin
        // hold the result port long enough that the block backs up into its input
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end
      stretch = $urandom_range(5, 80);
      mode    = $urandom_range(0, 3);
      for (int c = 0; c < stretch; c++) begin
        case (mode)
          0: out_stall_i <= 1'b0;                                // free flowing
          1: out_stall_i <= ($urandom_range(0, 3) == 0);         // light stalls
          2: out_stall_i <= ($urandom_range(0, 3) != 0);         // heavy stalls
          default: out_stall_i <= c[0];                          // alternating stalls
        endcase
        @(posedge clk_i);
      end
    end
  end

  // result checking: each result beat against the oldest outcome owed
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with nothing owed, status", out_beat_o.status, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_beat_o.found !== want.found)
          report_mismatch("found", out_beat_o.found, want.found);
        if (out_beat_o.status !== want.status)
          report_mismatch("status", out_beat_o.status, want.status);
      end
    end
  end

  // watchdog: a run of cycles with no beat moving on either side means a hang
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rsas_pkg.sv
rtl/core/rotated_sorted_array_search_top.sv
tb/rotated_sorted_array_search_top_tb.sv
